// ===== rtl/core/wheel_speed_pid_macros.svh =====
// Assertion helpers shared by the wheel speed controller modules.
// Both expect the including module to have ports named clock and reset.
`ifndef WHEEL_SPEED_PID_MACROS_SVH
`define WHEEL_SPEED_PID_MACROS_SVH

// Same-cycle implication.
`define WSP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WSP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/wsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

   // Divider geometry: numerator is |ticks| * 60e6 * 2560, denominator is tpr * dt.
   localparam int NUM_W     = 53;
   localparam int DEN_W     = 36;
   localparam int QUO_W     = 22;   // 21 result bits plus one overflow bit
   localparam int DIV_CNT_W = $clog2(QUO_W);

   // 60e6 * 2560 = 2343750 * 2^16; the low factor is applied as a shift.
   localparam logic signed [22:0] RPM_SCALE_HI = 23'sd2343750;
   localparam int RPM_SCALE_SHIFT = 16;

   localparam logic signed [20:0] SPD_MAX = 21'sd1048575;
   localparam logic signed [20:0] SPD_MIN = 21'h100000;
   localparam logic signed [17:0] CMD_LIM = 18'sd65280;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SET  = 2'd1;
   localparam logic [1:0] OP_HALT = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   localparam logic [2:0] CSR_GAIN_PROP  = 3'd0;
   localparam logic [2:0] CSR_GAIN_INTEG = 3'd1;
   localparam logic [2:0] CSR_GAIN_DERIV = 3'd2;
   localparam logic [2:0] CSR_INT_LIMIT  = 3'd3;
   localparam logic [2:0] CSR_TPR       = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MNUM,
      ST_MDEN,
      ST_DIV,
      ST_WAIT,
      ST_FILT,
      ST_MP,
      ST_MI,
      ST_MD,
      ST_ACC,
      ST_CMD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    done;
      logic                    ovf;
      logic [QUO_W-2:0]        quot;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/wsp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "wheel_speed_pid_macros.svh"

// Restoring divider, one quotient bit per cycle. Only the low quotient bits
// are kept; any quotient that does not fit raises the overflow bit.
module wsp_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [wsp_pkg::NUM_W-1:0]      num,
   input  wire logic [wsp_pkg::DEN_W-1:0]      den,
   output wsp_pkg::div_status_type             stat
);

   localparam int DSH_W = wsp_pkg::DEN_W + wsp_pkg::QUO_W - 1;

   logic [wsp_pkg::NUM_W-1:0]     rem_ff, rem_in;
   logic [DSH_W-1:0]              dsh_ff, dsh_in;
   logic [wsp_pkg::QUO_W-1:0]     q_ff, q_in;
   logic [wsp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic                          ge;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ge      = ({{(DSH_W - wsp_pkg::NUM_W){1'b0}}, rem_ff} >= dsh_ff);
      if (start) begin
         rem_in  = num;
         dsh_in  = {den, {(wsp_pkg::QUO_W - 1){1'b0}}};
         q_in    = '0;
         cnt_in  = wsp_pkg::DIV_CNT_W'(wsp_pkg::QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff[wsp_pkg::NUM_W-1:0];
         end
         q_in   = {q_ff[wsp_pkg::QUO_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign stat.done = done_ff;
   assign stat.ovf  = q_ff[wsp_pkg::QUO_W-1];
   assign stat.quot = q_ff[wsp_pkg::QUO_W-2:0];

   `WSP_ASSERT_NXT(a_start_busy, start, busy_ff, "divider did not start")
   `WSP_ASSERT_IMP(a_done_idle, done_ff, !busy_ff, "divider done while still busy")

endmodule

`default_nettype wire

// ===== rtl/core/wheel_speed_pid.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "wheel_speed_pid_macros.svh"

// Speed controller for one wheel motor. Each request item carries an opcode in
// req_tuser: a tick measures rpm, runs the PID step and updates the PWM duties,
// a set loads the target and leaves halt, a halt zeroes duties, command, target
// and error sum. Every item yields exactly one response item with the duties,
// the filtered rpm and the halt flag after that item. For a running tick, most
// of the work between acceptance and response is the 22-step serial divider
// that turns ticks and elapsed time into rpm, and the rest is one shared 17x23
// multiplier used five times in turn. Ticks while halted, the first running
// tick and all other opcodes skip those steps and go straight to the response.
// The block accepts one item at a time. Registers may be written at any time
// while no item is in progress; csr_ready is always high.
module wheel_speed_pid (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: encoder_ticks[15:0], elapsed_us[35:16], speed_target[56:36]
   input  wire logic [63:0] req_tdata,
   // req_tuser: opcode[1:0]
   input  wire logic [1:0]  req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: forward_duty[7:0], reverse_duty[15:8], measured_rpm[36:16],
   //            is_halted[37]
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [19:0] csr_data
);

   wsp_pkg::state_type state_ff, state_in;

   // Configuration.
   logic signed [15:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [19:0]        int_limit_ff;
   logic [15:0]        tpr_ff;

   // Controller state.
   logic               halted_ff, halted_in;
   logic               first_ff, first_in;
   logic signed [20:0] rpm_ff, rpm_in;
   logic signed [20:0] esum_ff, esum_in;
   logic signed [20:0] perr_ff, perr_in;
   logic signed [17:0] pcmd_ff, pcmd_in;
   logic signed [20:0] target_ff, target_in;
   logic [7:0]         duty_fwd_ff, duty_fwd_in;
   logic [7:0]         duty_rev_ff, duty_rev_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-item working registers.
   logic                        neg_ff, neg_in;
   logic [15:0]                 mag_ff, mag_in;
   logic [19:0]                 dt_ff, dt_in;
   logic [wsp_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [wsp_pkg::DEN_W-1:0]   den_ff, den_in;
   logic signed [20:0]          e_ff, e_in;
   logic signed [21:0]          diff_ff, diff_in;
   logic signed [39:0]          prod_ff, prod_in;
   logic signed [39:0]          acc_ff, acc_in;
   logic [7:0]                  rsp_fwd_ff, rsp_fwd_in;
   logic [7:0]                  rsp_rev_ff, rsp_rev_in;
   logic [20:0]                 rsp_rpm_ff, rsp_rpm_in;
   logic                        rsp_halt_ff, rsp_halt_in;

   // Shared multiplier.
   logic signed [16:0] mul_a;
   logic signed [22:0] mul_b;
   logic signed [39:0] mul_p;

   // Divider.
   logic                    div_start;
   wsp_pkg::div_status_type div_stat;

   // Datapath temporaries.
   logic [15:0]        req_ticks;
   logic [15:0]        tpr_eff;
   logic signed [20:0] inst;
   logic signed [21:0] inst_x, rpm_x, rdiff;
   logic signed [22:0] rstep, rsum;
   logic signed [20:0] rpm_new;
   logic signed [21:0] err_x;
   logic signed [20:0] err_sat;
   logic signed [31:0] cmd_raw;
   logic signed [32:0] cdiff;
   logic signed [33:0] cnew;
   logic signed [17:0] cmd_sat;
   logic signed [17:0] cmd_neg;
   logic signed [21:0] es_x, lim_x;
   logic               accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == wsp_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign req_ticks  = req_tdata[15:0];
   assign tpr_eff    = (tpr_ff == 16'd0) ? 16'd1 : tpr_ff;
   assign mul_p      = mul_a * mul_b;

   wsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .stat  (div_stat)
   );

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         wsp_pkg::ST_MNUM: begin
            mul_a = {1'b0, mag_ff};
            mul_b = wsp_pkg::RPM_SCALE_HI;
         end
         wsp_pkg::ST_MDEN: begin
            mul_a = {1'b0, tpr_eff};
            mul_b = {3'b000, dt_ff};
         end
         wsp_pkg::ST_MP: begin
            mul_a = gain_prop_ff;
            mul_b = e_ff;
         end
         wsp_pkg::ST_MI: begin
            mul_a = gain_integ_ff;
            mul_b = esum_ff;
         end
         wsp_pkg::ST_MD: begin
            mul_a = gain_deriv_ff;
            mul_b = diff_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Speed measurement and error, used in the filter step.
   always_comb begin
      if (!neg_ff) begin
         inst = (div_stat.ovf || div_stat.quot[20]) ? wsp_pkg::SPD_MAX
                                                     : $signed(div_stat.quot);
      end else begin
         inst = (div_stat.ovf || (div_stat.quot[20] && (div_stat.quot[19:0] != 20'd0)))
                ? wsp_pkg::SPD_MIN : $signed(~div_stat.quot + 21'd1);
      end
      inst_x = inst;
      rpm_x  = rpm_ff;
      rdiff  = inst_x - rpm_x;
      rstep  = rdiff >>> 2;
      rsum   = rstep + rpm_x;
      if (rsum > 23'sd1048575) begin
         rpm_new = wsp_pkg::SPD_MAX;
      end else if (rsum < -23'sd1048576) begin
         rpm_new = wsp_pkg::SPD_MIN;
      end else begin
         rpm_new = rsum[20:0];
      end
      err_x = target_ff - rpm_new;
      if (err_x > 22'sd1048575) begin
         err_sat = wsp_pkg::SPD_MAX;
      end else if (err_x < -22'sd1048576) begin
         err_sat = wsp_pkg::SPD_MIN;
      end else begin
         err_sat = err_x[20:0];
      end
   end

   // Command smoothing and error sum clamp, used in the command step.
   always_comb begin
      cmd_raw = acc_ff[39:8];
      cdiff   = cmd_raw - pcmd_ff;
      cnew    = (cdiff >>> 3) + pcmd_ff;
      if (cnew > 34'sd65280) begin
         cmd_sat = wsp_pkg::CMD_LIM;
      end else if (cnew < -34'sd65280) begin
         cmd_sat = -wsp_pkg::CMD_LIM;
      end else begin
         cmd_sat = cnew[17:0];
      end
      cmd_neg = -cmd_sat;
      es_x    = esum_ff + e_ff;
      lim_x   = $signed({2'b00, int_limit_ff});
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      halted_in    = halted_ff;
      first_in     = first_ff;
      rpm_in       = rpm_ff;
      esum_in      = esum_ff;
      perr_in      = perr_ff;
      pcmd_in      = pcmd_ff;
      target_in    = target_ff;
      duty_fwd_in  = duty_fwd_ff;
      duty_rev_in  = duty_rev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      dt_in        = dt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      e_in         = e_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      rsp_fwd_in   = rsp_fwd_ff;
      rsp_rev_in   = rsp_rev_ff;
      rsp_rpm_in   = rsp_rpm_ff;
      rsp_halt_in  = rsp_halt_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         wsp_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in   = req_ticks[15];
               mag_in   = req_ticks[15] ? (~req_ticks + 16'd1) : req_ticks;
               dt_in    = (req_tdata[35:16] == 20'd0) ? 20'd1 : req_tdata[35:16];
               state_in = wsp_pkg::ST_DONE;
               unique case (req_tuser)
                  wsp_pkg::OP_TICK: begin
                     if (halted_ff) begin
                        duty_fwd_in = 8'd0;
                        duty_rev_in = 8'd0;
                        esum_in     = '0;
                     end else if (first_ff) begin
                        // The first running tick only arms the interval timer.
                        first_in = 1'b0;
                     end else begin
                        state_in = wsp_pkg::ST_MNUM;
                     end
                  end
                  wsp_pkg::OP_SET: begin
                     target_in = req_tdata[56:36];
                     halted_in = 1'b0;
                  end
                  wsp_pkg::OP_HALT: begin
                     pcmd_in     = '0;
                     target_in   = '0;
                     esum_in     = '0;
                     halted_in   = 1'b1;
                     duty_fwd_in = 8'd0;
                     duty_rev_in = 8'd0;
                  end
                  wsp_pkg::OP_NONE: begin
                     halted_in = halted_ff;
                  end
               endcase
            end
         end
         wsp_pkg::ST_MNUM: begin
            num_in   = {mul_p[36:0], {wsp_pkg::RPM_SCALE_SHIFT{1'b0}}};
            state_in = wsp_pkg::ST_MDEN;
         end
         wsp_pkg::ST_MDEN: begin
            den_in   = mul_p[wsp_pkg::DEN_W-1:0];
            state_in = wsp_pkg::ST_DIV;
         end
         wsp_pkg::ST_DIV: begin
            div_start = 1'b1;
            state_in  = wsp_pkg::ST_WAIT;
         end
         wsp_pkg::ST_WAIT: begin
            if (div_stat.done) begin
               state_in = wsp_pkg::ST_FILT;
            end
         end
         wsp_pkg::ST_FILT: begin
            rpm_in   = rpm_new;
            e_in     = err_sat;
            diff_in  = err_sat - perr_ff;
            state_in = wsp_pkg::ST_MP;
         end
         wsp_pkg::ST_MP: begin
            prod_in  = mul_p;
            acc_in   = '0;
            state_in = wsp_pkg::ST_MI;
         end
         wsp_pkg::ST_MI: begin
            // The integral term uses the error sum from before this tick.
            prod_in  = mul_p;
            acc_in   = acc_ff + prod_ff;
            state_in = wsp_pkg::ST_MD;
         end
         wsp_pkg::ST_MD: begin
            prod_in  = mul_p;
            acc_in   = acc_ff + prod_ff;
            state_in = wsp_pkg::ST_ACC;
         end
         wsp_pkg::ST_ACC: begin
            acc_in   = acc_ff + prod_ff;
            state_in = wsp_pkg::ST_CMD;
         end
         wsp_pkg::ST_CMD: begin
            if (es_x < -lim_x) begin
               esum_in = 21'(-lim_x);
            end else if (es_x > lim_x) begin
               esum_in = lim_x[20:0];
            end else begin
               esum_in = es_x[20:0];
            end
            perr_in = e_ff;
            pcmd_in = cmd_sat;
            if (cmd_sat > 18'sd0) begin
               duty_fwd_in = cmd_sat[15:8];
               duty_rev_in = 8'd0;
            end else begin
               duty_fwd_in = 8'd0;
               duty_rev_in = cmd_neg[15:8];
            end
            state_in = wsp_pkg::ST_DONE;
         end
         wsp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_fwd_in   = duty_fwd_ff;
               rsp_rev_in   = duty_rev_ff;
               rsp_rpm_in   = rpm_ff;
               rsp_halt_in  = halted_ff;
               rsp_valid_in = 1'b1;
               state_in     = wsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsp_pkg::ST_IDLE;
         halted_ff    <= 1'b1;
         first_ff     <= 1'b1;
         rpm_ff       <= '0;
         esum_ff      <= '0;
         perr_ff      <= '0;
         pcmd_ff      <= '0;
         target_ff    <= '0;
         duty_fwd_ff  <= '0;
         duty_rev_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         first_ff     <= first_in;
         rpm_ff       <= rpm_in;
         esum_ff      <= esum_in;
         perr_ff      <= perr_in;
         pcmd_ff      <= pcmd_in;
         target_ff    <= target_in;
         duty_fwd_ff  <= duty_fwd_in;
         duty_rev_ff  <= duty_rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= 16'sd1280;
         gain_integ_ff <= 16'sd0;
         gain_deriv_ff <= 16'sd0;
         int_limit_ff  <= 20'd12800;
         tpr_ff        <= 16'd29946;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wsp_pkg::CSR_GAIN_PROP:  gain_prop_ff  <= csr_data[15:0];
            wsp_pkg::CSR_GAIN_INTEG: gain_integ_ff <= csr_data[15:0];
            wsp_pkg::CSR_GAIN_DERIV: gain_deriv_ff <= csr_data[15:0];
            wsp_pkg::CSR_INT_LIMIT:  int_limit_ff  <= csr_data;
            wsp_pkg::CSR_TPR:        tpr_ff        <= csr_data[15:0];
            default: begin
               tpr_ff <= tpr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      dt_ff       <= dt_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      e_ff        <= e_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_fwd_ff  <= rsp_fwd_in;
      rsp_rev_ff  <= rsp_rev_in;
      rsp_rpm_ff  <= rsp_rpm_in;
      rsp_halt_ff <= rsp_halt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_halt_ff, rsp_rpm_ff, rsp_rev_ff, rsp_fwd_ff};

   `WSP_ASSERT_IMP(a_halt_quiet, halted_ff,
      (duty_fwd_ff == 8'd0) && (duty_rev_ff == 8'd0) && (esum_ff == '0) && (pcmd_ff == '0),
      "halted controller holds a nonzero duty, command or error sum")
   `WSP_ASSERT_NXT(a_accept_busy, accept, state_ff != wsp_pkg::ST_IDLE,
      "accepted item did not leave idle")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam longint SPEED_SCALE = 64'sd153600000000;
   localparam longint SPEED_HI = 64'sd1048575;
   localparam longint SPEED_LO = -64'sd1048576;
   localparam longint COMMAND_LIM = 64'sd65280;
   // No register sits at this index; writes to it must leave every setting alone.
   localparam logic [2:0] CSR_SPARE = 3'd7;
   localparam int IDLE_PCT = 29;
   localparam int HOLD_AT = 250;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_COUNT = 7;
   localparam int PHASE_ITEMS = 145;
   localparam int CALM_PHASE = 3;

   typedef struct packed {
      logic        is_halted;
      logic [20:0] measured_rpm;
      logic [7:0]  reverse_duty;
      logic [7:0]  forward_duty;
   } motor_out_type;

   class speed_pid_scoreboard;
      longint kp, ki, kd, sum_limit, tenths_per_rev;
      longint rpm_filt, err_sum, prev_err, prev_cmd, target;
      bit halted, arm_pending;
      logic [7:0] fwd, rev;
      motor_out_type expected_outputs[$];
      int errors;

      function new();
         kp = 1280;
         ki = 0;
         kd = 0;
         sum_limit = 12800;
         tenths_per_rev = 29946;
         rpm_filt = 0;
         err_sum = 0;
         prev_err = 0;
         prev_cmd = 0;
         target = 0;
         halted = 1'b1;
         arm_pending = 1'b1;
         fwd = '0;
         rev = '0;
         errors = 0;
      endfunction

      function longint clamp(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      function void set_reg(logic [2:0] idx, logic [19:0] data);
         case (idx)
            wsp_pkg::CSR_GAIN_PROP:  kp = $signed(data[15:0]);
            wsp_pkg::CSR_GAIN_INTEG: ki = $signed(data[15:0]);
            wsp_pkg::CSR_GAIN_DERIV: kd = $signed(data[15:0]);
            wsp_pkg::CSR_INT_LIMIT:  sum_limit = data;
            wsp_pkg::CSR_TPR:        tenths_per_rev = data[15:0];
            default: ;
         endcase
      endfunction

      // One control step: speed estimate, filtering, PID and duty split.
      function void advance_speed_loop(logic [15:0] ticks, logic [19:0] elapsed);
         longint tk, dt, tpr, spd, e, diff, cmd;
         if (halted) begin
            fwd = '0;
            rev = '0;
            err_sum = 0;
            return;
         end
         if (arm_pending) begin
            arm_pending = 1'b0;
            return;
         end
         tk = $signed(ticks);
         dt = elapsed;
         if (dt == 0) dt = 1;
         tpr = (tenths_per_rev == 0) ? 1 : tenths_per_rev;
         spd = clamp((tk * SPEED_SCALE) / (tpr * dt), SPEED_LO, SPEED_HI);
         rpm_filt = clamp(rpm_filt + ((spd - rpm_filt) >>> 2), SPEED_LO, SPEED_HI);
         e = clamp(target - rpm_filt, SPEED_LO, SPEED_HI);
         diff = e - prev_err;
         cmd = (kp * e + ki * err_sum + kd * diff) >>> 8;
         err_sum = clamp(err_sum + e, -sum_limit, sum_limit);
         prev_err = e;
         cmd = clamp(prev_cmd + ((cmd - prev_cmd) >>> 3), -COMMAND_LIM, COMMAND_LIM);
         prev_cmd = cmd;
         if (cmd > 0) begin
            fwd = 8'(cmd >>> 8);
            rev = '0;
         end else begin
            fwd = '0;
            rev = 8'((-cmd) >>> 8);
         end
      endfunction

      function void note_request(logic [1:0] op, logic [15:0] ticks, logic [19:0] elapsed,
                                 logic [20:0] tgt);
         motor_out_type want;
         case (op)
            wsp_pkg::OP_TICK: advance_speed_loop(ticks, elapsed);
            wsp_pkg::OP_SET: begin
               target = $signed(tgt);
               halted = 1'b0;
            end
            wsp_pkg::OP_HALT: begin
               prev_cmd = 0;
               target = 0;
               err_sum = 0;
               halted = 1'b1;
               fwd = '0;
               rev = '0;
            end
            default: ;
         endcase
         want.forward_duty = fwd;
         want.reverse_duty = rev;
         want.measured_rpm = rpm_filt[20:0];
         want.is_halted = halted;
         expected_outputs.push_back(want);
      endfunction

      function void check_response(logic [39:0] data);
         motor_out_type got, want;
         got = data[37:0];
         if (expected_outputs.size() == 0) begin
            $error("response item arrived with nothing outstanding");
            errors++;
            return;
         end
         want = expected_outputs.pop_front();
         if (got.forward_duty !== want.forward_duty) begin
            $error("forward_duty: expected %0d, got %0d", want.forward_duty, got.forward_duty);
            errors++;
         end
         if (got.reverse_duty !== want.reverse_duty) begin
            $error("reverse_duty: expected %0d, got %0d", want.reverse_duty, got.reverse_duty);
            errors++;
         end
         if (got.measured_rpm !== want.measured_rpm) begin
            $error("measured_rpm: expected %0d, got %0d",
                   $signed(want.measured_rpm), $signed(got.measured_rpm));
            errors++;
         end
         if (got.is_halted !== want.is_halted) begin
            $error("is_halted: expected %0d, got %0d", want.is_halted, got.is_halted);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [19:0] csr_data;

   speed_pid_scoreboard sb = new();
   bit calm = 1'b0;

   wheel_speed_pid i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit pause_now();
      return !calm && ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   function automatic logic [15:0] pick_ticks();
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 400) - 200);
   endfunction

   function automatic logic [19:0] pick_elapsed();
      if ($urandom_range(0, 3) == 0) return 20'($urandom);
      return 20'($urandom_range(15000, 25000));
   endfunction

   function automatic logic [20:0] pick_target();
      if ($urandom_range(0, 3) == 0) return 21'($urandom);
      return 21'(($urandom_range(0, 600) - 300) * 256);
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [15:0] ticks,
                            input logic [19:0] elapsed, input logic [20:0] tgt);
      while (pause_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser <= op;
      req_tdata <= {7'd0, tgt, elapsed, ticks};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, ticks, elapsed, tgt);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [19:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, value);
   endtask

   // Stops offering items and waits until every response is back, so the block is idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic apply_settings(input int phase);
      logic [15:0] p_gain, i_gain, d_gain, tpr;
      logic [19:0] limit;
      case (phase)
         0: begin
            p_gain = 16'h7FFF;
            i_gain = 16'h7FFF;
            d_gain = 16'h7FFF;
            limit = 20'hFFFFF;
            tpr = 16'hFFFF;
         end
         1: begin
            p_gain = 16'h8000;
            i_gain = 16'h8000;
            d_gain = 16'h8000;
            limit = '0;
            tpr = 16'd1;
         end
         2: begin
            // A zero tick count per revolution must behave like one.
            p_gain = 16'd1280;
            i_gain = 16'd64;
            d_gain = 16'd256;
            limit = 20'd12800;
            tpr = '0;
         end
         6: begin
            p_gain = 16'($urandom);
            i_gain = 16'($urandom);
            d_gain = 16'($urandom);
            limit = 20'($urandom);
            tpr = 16'($urandom_range(1, 65535));
         end
         default: begin
            p_gain = 16'($urandom_range(0, 3000));
            i_gain = 16'($urandom_range(0, 200));
            d_gain = 16'($urandom_range(0, 800));
            limit = 20'($urandom_range(0, 200000));
            tpr = 16'($urandom_range(1000, 65535));
         end
      endcase
      write_reg(wsp_pkg::CSR_GAIN_PROP, {4'd0, p_gain});
      write_reg(wsp_pkg::CSR_GAIN_INTEG, {4'd0, i_gain});
      write_reg(wsp_pkg::CSR_GAIN_DERIV, {4'd0, d_gain});
      write_reg(wsp_pkg::CSR_INT_LIMIT, limit);
      write_reg(wsp_pkg::CSR_TPR, {4'd0, tpr});
      if (phase == 4) write_reg(CSR_SPARE, 20'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      send_item(wsp_pkg::OP_TICK, 16'd100, 20'd20000, '0);
      send_item(wsp_pkg::OP_NONE, 16'hFFFF, 20'hFFFFF, 21'h1FFFFF);
      send_item(wsp_pkg::OP_HALT, '0, '0, '0);
      send_item(wsp_pkg::OP_SET, '0, '0, 21'd25600);
      // The first running tick only arms the timer.
      send_item(wsp_pkg::OP_TICK, 16'd100, 20'd20000, '0);
      send_item(wsp_pkg::OP_TICK, 16'd100, 20'd20000, '0);
      send_item(wsp_pkg::OP_TICK, 16'd98, 20'd20000, '0);
      send_item(wsp_pkg::OP_TICK, 16'd1, 20'd0, '0);
      send_item(wsp_pkg::OP_TICK, 16'h8000, 20'd0, '0);
      send_item(wsp_pkg::OP_TICK, 16'h7FFF, 20'hFFFFF, '0);
      send_item(wsp_pkg::OP_SET, '0, '0, 21'h0FFFFF);
      send_item(wsp_pkg::OP_TICK, 16'd0, 20'd20000, '0);
      send_item(wsp_pkg::OP_TICK, 16'd0, 20'd20000, '0);
      send_item(wsp_pkg::OP_SET, '0, '0, 21'h100000);
      send_item(wsp_pkg::OP_TICK, 16'h8000, 20'd1, '0);
      send_item(wsp_pkg::OP_TICK, -16'sd50, 20'd20000, '0);
      send_item(wsp_pkg::OP_HALT, '0, '0, '0);
      send_item(wsp_pkg::OP_TICK, 16'd200, 20'd20000, '0);
      send_item(wsp_pkg::OP_SET, '0, '0, '0);
      // A halt does not re-arm the discarded first tick, so this one runs.
      send_item(wsp_pkg::OP_TICK, 16'd0, 20'd20000, '0);
      send_item(wsp_pkg::OP_TICK, 16'h7FFF, 20'hFFFFF, '0);
      send_item(wsp_pkg::OP_NONE, '0, '0, '0);
      send_item(wsp_pkg::OP_HALT, '0, '0, '0);
      send_item(wsp_pkg::OP_SET, '0, '0, 21'h1FCE00);
      send_item(wsp_pkg::OP_TICK, -16'sd50, 20'd20000, '0);
   endtask

   // Mostly running ticks after a set, with occasional retargets, halts and unused opcodes.
   task automatic run_phase(input int count);
      logic [1:0] op;
      int roll;
      bit after_halt;
      after_halt = 1'b0;
      send_item(wsp_pkg::OP_SET, pick_ticks(), pick_elapsed(), pick_target());
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (after_halt && roll < 80) op = wsp_pkg::OP_SET;
         else if (roll < 3) op = wsp_pkg::OP_HALT;
         else if (roll < 6) op = wsp_pkg::OP_NONE;
         else if (roll < 16) op = wsp_pkg::OP_SET;
         else op = wsp_pkg::OP_TICK;
         after_halt = (op == wsp_pkg::OP_HALT);
         send_item(op, pick_ticks(), pick_elapsed(), pick_target());
      end
   endtask

   initial begin : response_sink
      int hold_left;
      int taken;
      bit held;
      hold_left = 0;
      taken = 0;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
            taken++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!held && taken == HOLD_AT) begin
            // Long back-pressure so the block fills and stalls its input.
            held = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !pause_now();
         end
      end
   end

   initial begin : stimulus
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= wsp_pkg::OP_NONE;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         apply_settings(p);
         calm = (p == CALM_PHASE);
         run_phase(PHASE_ITEMS);
      end
      settle();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.expected_outputs.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #5000000;
      $display("tb: errors");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/wsp_pkg.sv
rtl/core/wsp_div.sv
rtl/core/wheel_speed_pid.sv
bench/tb.sv
